FILE: rtl/core/ghdm_pkg.sv
// Shared types and constants for the grid Hamming descriptor matcher.
// No dependencies; every other file in rtl/core refers to this package.
package ghdm_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 64;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 6;
  localparam int CELL_W    = ROW_W + COL_W;
  localparam int WORD_W    = 64;
  localparam int DESC_W    = 4 * WORD_W;
  localparam int CNT_W     = 7;
  localparam int DIST_W    = 9;
  localparam int RAD_W     = 2;
  localparam int RIU_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd2;

  localparam logic [DIST_W-1:0] THRESHOLD_RST = 9'd64;
  localparam logic [RAD_W-1:0]  RADIUS_RST    = 2'd1;
  localparam logic [RIU_W-1:0]  ROWS_RST      = 6'd32;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [DIST_W-1:0] threshold;
    logic [RAD_W-1:0]  row_radius;
    logic [RIU_W-1:0]  rows_in_use;
  } cfg_t;

  typedef struct packed {
    logic              load_en;
    logic              clear_en;
    logic [CELL_W-1:0] clear_addr;
    logic              query_start;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic [COL_W-1:0]  rd_col;
    logic              result_en;
  } cmd_t;

endpackage

FILE: rtl/core/grid_hamming_descriptor_matcher_top.sv
// Top level of the grid Hamming descriptor matcher.
// Depends on ghdm_pkg, ghdm_cfg, ghdm_ctrl and ghdm_datapath.
//
// Usage:
//   Input transactions are taken at a rising edge with start high and busy low.
//   in_func selects a load (write one grid cell's descriptor and valid bit) or
//   a query (search for the best Hamming match near in_grid_row/in_grid_col).
//   A load gives no result; busy stays low.
//   A query gives exactly one result, shown for one cycle with out_strobe high.
//   Rows in the window are scanned upward, columns 0 to query column - 1, one
//   cell per cycle through a single descriptor store read port feeding a
//   three-stage XOR/popcount/compare pipeline. A query with nothing to search
//   skips the scan; busy drops the cycle after the result strobe.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   the user must make them only while the block is idle (not enforced).
//   After reset the valid store is swept clear, one cell a cycle, over all
//   2048 cells; busy is high during the sweep, configuration writes are taken.
//   The receiver cannot stall: each result must be taken in its strobe cycle.
module grid_hamming_descriptor_matcher_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [ghdm_pkg::ROW_W-1:0]      in_grid_row,
  input  logic [ghdm_pkg::COL_W-1:0]      in_grid_col,
  input  logic                            in_entry_valid,
  input  logic [ghdm_pkg::WORD_W-1:0]     in_desc_word0,
  input  logic [ghdm_pkg::WORD_W-1:0]     in_desc_word1,
  input  logic [ghdm_pkg::WORD_W-1:0]     in_desc_word2,
  input  logic [ghdm_pkg::WORD_W-1:0]     in_desc_word3,
  output logic                            out_strobe,
  output logic                            out_found,
  output logic [ghdm_pkg::ROW_W-1:0]      out_match_row,
  output logic [ghdm_pkg::COL_W-1:0]      out_match_col,
  output logic [ghdm_pkg::DIST_W-1:0]     out_distance,
  input  logic                            cfg_we,
  input  logic [ghdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ghdm_pkg::CFG_DAT_W-1:0]  cfg_data
);

  ghdm_pkg::cfg_t cfg;
  ghdm_pkg::cmd_t cmd;

  ghdm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ghdm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_func        (in_func),
    .in_grid_row    (in_grid_row),
    .in_grid_col    (in_grid_col),
    .in_entry_valid (in_entry_valid),
    .cfg            (cfg),
    .busy           (busy),
    .cmd            (cmd)
  );

  ghdm_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg),
    .in_grid_row    (in_grid_row),
    .in_grid_col    (in_grid_col),
    .in_entry_valid (in_entry_valid),
    .in_desc_word0  (in_desc_word0),
    .in_desc_word1  (in_desc_word1),
    .in_desc_word2  (in_desc_word2),
    .in_desc_word3  (in_desc_word3),
    .out_strobe     (out_strobe),
    .out_found      (out_found),
    .out_match_row  (out_match_row),
    .out_match_col  (out_match_col),
    .out_distance   (out_distance)
  );

endmodule

FILE: rtl/core/ghdm_cfg.sv
// Configuration registers of the matcher: threshold, row radius, rows in use.
// Depends on ghdm_pkg.
module ghdm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ghdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ghdm_pkg::CFG_DAT_W-1:0] cfg_data,
  output ghdm_pkg::cfg_t                 cfg
);

  logic [ghdm_pkg::DIST_W-1:0] threshold_r;
  logic [ghdm_pkg::RAD_W-1:0]  radius_r;
  logic [ghdm_pkg::RIU_W-1:0]  rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= ghdm_pkg::THRESHOLD_RST;
      radius_r    <= ghdm_pkg::RADIUS_RST;
      rows_r      <= ghdm_pkg::ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ghdm_pkg::CFG_THRESHOLD: threshold_r <= cfg_data[ghdm_pkg::DIST_W-1:0];
        ghdm_pkg::CFG_RADIUS:    radius_r    <= cfg_data[ghdm_pkg::RAD_W-1:0];
        ghdm_pkg::CFG_ROWS:      rows_r      <= cfg_data[ghdm_pkg::RIU_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.threshold   = threshold_r;
  assign cfg.row_radius  = radius_r;
  assign cfg.rows_in_use = rows_r;

endmodule

FILE: rtl/core/ghdm_ctrl.sv
// Controller of the matcher: clearing sweep, load issue and the row/column scan.
// Depends on ghdm_pkg; drives ghdm_datapath through ghdm_pkg::cmd_t.
module ghdm_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       in_func,
  input  logic [ghdm_pkg::ROW_W-1:0] in_grid_row,
  input  logic [ghdm_pkg::COL_W-1:0] in_grid_col,
  input  logic                       in_entry_valid,
  input  ghdm_pkg::cfg_t             cfg,
  output logic                       busy,
  output ghdm_pkg::cmd_t             cmd
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_DRAIN_A = 3'd3;
  localparam logic [2:0] S_DRAIN_B = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic [ghdm_pkg::CELL_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ghdm_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [ghdm_pkg::ROW_W-1:0]  hi_r, hi_nxt;
  logic [ghdm_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [ghdm_pkg::COL_W-1:0]  col_last_r, col_last_nxt;

  logic                        accept;
  logic [ghdm_pkg::RIU_W-1:0]  used;
  logic [ghdm_pkg::ROW_W-1:0]  lo;
  logic [ghdm_pkg::RIU_W-1:0]  hi_raw;
  logic [ghdm_pkg::RIU_W-1:0]  hi_lim;
  logic [ghdm_pkg::RIU_W-1:0]  hi_clip;
  logic                        empty;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);

  // Row window of the query, limited to rows in use
  always_comb begin
    used = (cfg.rows_in_use > ghdm_pkg::RIU_W'(ghdm_pkg::GRID_ROWS)) ?
           ghdm_pkg::RIU_W'(ghdm_pkg::GRID_ROWS) : cfg.rows_in_use;
    lo = (in_grid_row >= ghdm_pkg::ROW_W'(cfg.row_radius)) ?
         in_grid_row - ghdm_pkg::ROW_W'(cfg.row_radius) : '0;
    hi_raw  = ghdm_pkg::RIU_W'(in_grid_row) + ghdm_pkg::RIU_W'(cfg.row_radius);
    hi_lim  = used - ghdm_pkg::RIU_W'(1);
    hi_clip = (hi_raw > hi_lim) ? hi_lim : hi_raw;
    empty   = !in_entry_valid || (used == '0) || (in_grid_col == '0) ||
              (ghdm_pkg::RIU_W'(lo) > hi_clip);
  end

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    row_nxt      = row_r;
    hi_nxt       = hi_r;
    col_nxt      = col_r;
    col_last_nxt = col_last_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ghdm_pkg::CELL_W'(1);
        if (clr_cnt_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept && in_func == ghdm_pkg::FUNC_QUERY) begin
          row_nxt      = lo;
          hi_nxt       = hi_clip[ghdm_pkg::ROW_W-1:0];
          col_nxt      = '0;
          col_last_nxt = in_grid_col - ghdm_pkg::COL_W'(1);
          state_nxt    = empty ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (col_r == col_last_r) begin
          col_nxt = '0;
          if (row_r == hi_r) state_nxt = S_DRAIN_A;
          else row_nxt = row_r + ghdm_pkg::ROW_W'(1);
        end else begin
          col_nxt = col_r + ghdm_pkg::COL_W'(1);
        end
      end
      S_DRAIN_A: state_nxt = S_DRAIN_B;
      S_DRAIN_B: state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    hi_r       <= hi_nxt;
    col_r      <= col_nxt;
    col_last_r <= col_last_nxt;
  end

  always_comb begin
    cmd.load_en     = accept && (in_func == ghdm_pkg::FUNC_LOAD);
    cmd.clear_en    = (state_r == S_CLEAR);
    cmd.clear_addr  = clr_cnt_r;
    cmd.query_start = accept && (in_func == ghdm_pkg::FUNC_QUERY);
    cmd.rd_en       = (state_r == S_SCAN);
    cmd.rd_row      = row_r;
    cmd.rd_col      = col_r;
    cmd.result_en   = (state_r == S_DONE);
  end

endmodule

FILE: rtl/core/ghdm_datapath.sv
// Datapath of the matcher: descriptor and valid stores, XOR/popcount pipeline
// and best-match tracking. Depends on ghdm_pkg; commanded by ghdm_ctrl.
module ghdm_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ghdm_pkg::cmd_t               cmd,
  input  ghdm_pkg::cfg_t               cfg,
  input  logic [ghdm_pkg::ROW_W-1:0]   in_grid_row,
  input  logic [ghdm_pkg::COL_W-1:0]   in_grid_col,
  input  logic                         in_entry_valid,
  input  logic [ghdm_pkg::WORD_W-1:0]  in_desc_word0,
  input  logic [ghdm_pkg::WORD_W-1:0]  in_desc_word1,
  input  logic [ghdm_pkg::WORD_W-1:0]  in_desc_word2,
  input  logic [ghdm_pkg::WORD_W-1:0]  in_desc_word3,
  output logic                         out_strobe,
  output logic                         out_found,
  output logic [ghdm_pkg::ROW_W-1:0]   out_match_row,
  output logic [ghdm_pkg::COL_W-1:0]   out_match_col,
  output logic [ghdm_pkg::DIST_W-1:0]  out_distance
);

  localparam int CELLS = ghdm_pkg::GRID_ROWS * ghdm_pkg::GRID_COLS;

  function automatic logic [ghdm_pkg::CNT_W-1:0] pop64(
    input logic [ghdm_pkg::WORD_W-1:0] v
  );
    logic [ghdm_pkg::WORD_W-1:0] a;
    logic [ghdm_pkg::WORD_W-1:0] b;
    logic [ghdm_pkg::WORD_W-1:0] c;
    logic [ghdm_pkg::CNT_W-1:0]  s;
    a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + ghdm_pkg::CNT_W'(c[8*i +: 8]);
    end
    return s;
  endfunction

  logic [ghdm_pkg::DESC_W-1:0] desc_mem [CELLS];
  logic                        valid_mem [CELLS];

  logic [ghdm_pkg::CELL_W-1:0] ld_addr;
  logic [ghdm_pkg::CELL_W-1:0] rd_addr;
  logic [ghdm_pkg::CELL_W-1:0] vw_addr;
  logic                        vw_en;
  logic                        vw_data;

  logic [ghdm_pkg::DESC_W-1:0] q_desc_r;

  // Stage 1: store read
  logic [ghdm_pkg::DESC_W-1:0] rd_desc_r;
  logic                        rd_valid_r;
  logic                        s1_vld_r;
  logic [ghdm_pkg::ROW_W-1:0]  s1_row_r;
  logic [ghdm_pkg::COL_W-1:0]  s1_col_r;

  // Stage 2: per-word popcount
  logic [ghdm_pkg::CNT_W-1:0]  cnt_r [4];
  logic                        s2_vld_r;
  logic [ghdm_pkg::ROW_W-1:0]  s2_row_r;
  logic [ghdm_pkg::COL_W-1:0]  s2_col_r;
  logic [ghdm_pkg::DESC_W-1:0] diff;

  // Stage 3: best tracking
  logic [ghdm_pkg::DIST_W-1:0] cand_dist;
  logic                        better;
  logic                        best_found_r;
  logic [ghdm_pkg::DIST_W-1:0] best_dist_r;
  logic [ghdm_pkg::ROW_W-1:0]  best_row_r;
  logic [ghdm_pkg::COL_W-1:0]  best_col_r;

  assign ld_addr = {in_grid_row, in_grid_col};
  assign rd_addr = {cmd.rd_row, cmd.rd_col};
  assign vw_en   = cmd.load_en || cmd.clear_en;
  assign vw_addr = cmd.clear_en ? cmd.clear_addr : ld_addr;
  assign vw_data = cmd.clear_en ? 1'b0 : in_entry_valid;

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      desc_mem[ld_addr] <= {in_desc_word3, in_desc_word2, in_desc_word1, in_desc_word0};
    end
    if (cmd.rd_en) begin
      rd_desc_r <= desc_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (vw_en) begin
      valid_mem[vw_addr] <= vw_data;
    end
    if (cmd.rd_en) begin
      rd_valid_r <= valid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_desc_r <= {in_desc_word3, in_desc_word2, in_desc_word1, in_desc_word0};
    end
  end

  assign diff = rd_desc_r ^ q_desc_r;

  always_ff @(posedge clk) begin
    s1_row_r <= cmd.rd_row;
    s1_col_r <= cmd.rd_col;
    s2_row_r <= s1_row_r;
    s2_col_r <= s1_col_r;
    for (int w = 0; w < 4; w++) begin
      cnt_r[w] <= pop64(diff[ghdm_pkg::WORD_W*w +: ghdm_pkg::WORD_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.rd_en;
      s2_vld_r <= s1_vld_r && rd_valid_r;
    end
  end

  always_comb begin
    cand_dist = ghdm_pkg::DIST_W'(cnt_r[0]) + ghdm_pkg::DIST_W'(cnt_r[1]) +
                ghdm_pkg::DIST_W'(cnt_r[2]) + ghdm_pkg::DIST_W'(cnt_r[3]);
    // Strictly smaller only: the first cell at the best distance wins
    better = s2_vld_r && (cand_dist <= cfg.threshold) &&
             (!best_found_r || cand_dist < best_dist_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.query_start) begin
      best_found_r <= 1'b0;
      best_dist_r  <= '0;
      best_row_r   <= '0;
      best_col_r   <= '0;
    end else if (better) begin
      best_found_r <= 1'b1;
      best_dist_r  <= cand_dist;
      best_row_r   <= s2_row_r;
      best_col_r   <= s2_col_r;
    end
  end

  assign out_strobe    = cmd.result_en;
  assign out_found     = best_found_r;
  assign out_match_row = best_row_r;
  assign out_match_col = best_col_r;
  assign out_distance  = best_dist_r;

endmodule
